// ----- hw/rtl/ile_pkg.sv -----
// ============================================================================
// ile_pkg: shared types and constants for the indexed list engine
// Word layouts, operation and status codes, and the command/status bundles
// between the list controller and the list datapath.
// ============================================================================
package ile_pkg;

    // list sizing
    localparam int CAPACITY     = 64;
    localparam int PAYLOAD_BITS = 32;
    localparam int ADDR_W       = $clog2(CAPACITY);

    // fixed field widths
    localparam int MODE_W   = 3;
    localparam int POS_W    = 7;
    localparam int DATA_W   = 32;
    localparam int STATUS_W = 2;
    localparam int CNT_W    = 7;

    // operation codes
    localparam logic [MODE_W-1:0] MODE_APPEND = 3'd0;
    localparam logic [MODE_W-1:0] MODE_INSERT = 3'd1;
    localparam logic [MODE_W-1:0] MODE_READ   = 3'd2;
    localparam logic [MODE_W-1:0] MODE_POP    = 3'd3;
    localparam logic [MODE_W-1:0] MODE_REMOVE = 3'd4;
    localparam logic [MODE_W-1:0] MODE_CLEAR  = 3'd5;

    // status codes
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_RANGE = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd3;

    // input word
    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [POS_W-1:0]  position;
        logic [DATA_W-1:0] payload_in;
    } ile_in_t;

    // output word
    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [DATA_W-1:0]   payload_out;
        logic [CNT_W-1:0]    count_after;
    } ile_out_t;

    // memory read address select
    typedef enum logic [1:0] {
        RD_POS,
        RD_LAST,
        RD_PREV,
        RD_NEXT
    } ile_rd_sel_t;

    // memory write address/data select
    typedef enum logic [1:0] {
        WR_TAIL,
        WR_POS,
        WR_UP,
        WR_DOWN
    } ile_wr_sel_t;

    // entry count update
    typedef enum logic [1:0] {
        CNT_HOLD,
        CNT_INC,
        CNT_DEC,
        CNT_CLR
    } ile_cnt_op_t;

    // controller -> datapath
    typedef struct packed {
        logic                op_load;
        logic                rd_en;
        ile_rd_sel_t         rd_sel;
        logic                wr_en;
        ile_wr_sel_t         wr_sel;
        ile_cnt_op_t         cnt_op;
        logic                res_grab;
        logic                status_load;
        logic [STATUS_W-1:0] status_val;
        logic                out_load;
    } ile_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic              is_empty;
        logic              is_full;
        logic              pos_gt_cnt;
        logic              pos_ge_cnt;
        logic              pos_eq_cnt;
        logic              ptr_at_pos;
        logic              ptr_at_last;
        logic              out_free;
    } ile_stat_t;

endpackage

// ----- hw/rtl/ile_ctrl.sv -----
// ============================================================================
// ile_ctrl: list operation sequencer
// Decodes the latched operation, checks errors, and steps the datapath
// through single accesses or the one-entry-per-cycle shift of the store.
// ============================================================================
module ile_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  ile_pkg::ile_stat_t stat,
    output ile_pkg::ile_cmd_t  cmd
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_DECIDE = 3'd1;
    localparam logic [2:0] S_GRAB   = 3'd2;
    localparam logic [2:0] S_UP     = 3'd3;
    localparam logic [2:0] S_PUT    = 3'd4;
    localparam logic [2:0] S_DOWN   = 3'd5;
    localparam logic [2:0] S_FINISH = 3'd6;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_ready = (state_reg == S_IDLE);

    // next state and commands
    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.op_load = 1'b1;
                    state_next  = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                state_next      = S_FINISH;
                cmd.status_load = 1'b1;
                cmd.status_val  = ile_pkg::ST_OK;
                unique case (stat.mode)
                    ile_pkg::MODE_APPEND:
                    begin
                        if (stat.is_full)
                        begin
                            cmd.status_val = ile_pkg::ST_FULL;
                        end
                        else
                        begin
                            cmd.wr_en  = 1'b1;
                            cmd.wr_sel = ile_pkg::WR_TAIL;
                            cmd.cnt_op = ile_pkg::CNT_INC;
                        end
                    end
                    ile_pkg::MODE_INSERT:
                    begin
                        if (stat.pos_gt_cnt)
                        begin
                            cmd.status_val = ile_pkg::ST_RANGE;
                        end
                        else if (stat.is_full)
                        begin
                            cmd.status_val = ile_pkg::ST_FULL;
                        end
                        else if (stat.pos_eq_cnt)
                        begin
                            cmd.wr_en  = 1'b1;
                            cmd.wr_sel = ile_pkg::WR_POS;
                            cmd.cnt_op = ile_pkg::CNT_INC;
                        end
                        else
                        begin
                            // shift tail up, starting at the last entry
                            cmd.rd_en  = 1'b1;
                            cmd.rd_sel = ile_pkg::RD_LAST;
                            state_next = S_UP;
                        end
                    end
                    ile_pkg::MODE_READ:
                    begin
                        if (stat.pos_ge_cnt)
                        begin
                            cmd.status_val = ile_pkg::ST_RANGE;
                        end
                        else
                        begin
                            cmd.rd_en  = 1'b1;
                            cmd.rd_sel = ile_pkg::RD_POS;
                            state_next = S_GRAB;
                        end
                    end
                    ile_pkg::MODE_POP:
                    begin
                        if (stat.is_empty)
                        begin
                            cmd.status_val = ile_pkg::ST_EMPTY;
                        end
                        else
                        begin
                            cmd.rd_en  = 1'b1;
                            cmd.rd_sel = ile_pkg::RD_LAST;
                            state_next = S_GRAB;
                        end
                    end
                    ile_pkg::MODE_REMOVE:
                    begin
                        if (stat.is_empty)
                        begin
                            cmd.status_val = ile_pkg::ST_EMPTY;
                        end
                        else if (stat.pos_ge_cnt)
                        begin
                            cmd.status_val = ile_pkg::ST_RANGE;
                        end
                        else
                        begin
                            cmd.rd_en  = 1'b1;
                            cmd.rd_sel = ile_pkg::RD_POS;
                            state_next = S_GRAB;
                        end
                    end
                    ile_pkg::MODE_CLEAR:
                    begin
                        cmd.cnt_op = ile_pkg::CNT_CLR;
                    end
                    default:
                    begin
                        // unused modes: no change
                    end
                endcase
            end
            S_GRAB:
            begin
                cmd.res_grab = 1'b1;
                if ((stat.mode == ile_pkg::MODE_REMOVE) && !stat.ptr_at_last)
                begin
                    // close the gap, starting just above the removed entry
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = ile_pkg::RD_NEXT;
                    state_next = S_DOWN;
                end
                else
                begin
                    if ((stat.mode == ile_pkg::MODE_POP) ||
                        (stat.mode == ile_pkg::MODE_REMOVE))
                    begin
                        cmd.cnt_op = ile_pkg::CNT_DEC;
                    end
                    state_next = S_FINISH;
                end
            end
            S_UP:
            begin
                // move entry ptr to ptr+1, fetch the one below
                cmd.wr_en  = 1'b1;
                cmd.wr_sel = ile_pkg::WR_UP;
                if (stat.ptr_at_pos)
                begin
                    state_next = S_PUT;
                end
                else
                begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = ile_pkg::RD_PREV;
                end
            end
            S_PUT:
            begin
                cmd.wr_en  = 1'b1;
                cmd.wr_sel = ile_pkg::WR_POS;
                cmd.cnt_op = ile_pkg::CNT_INC;
                state_next = S_FINISH;
            end
            S_DOWN:
            begin
                // move entry ptr to ptr-1, fetch the one above
                cmd.wr_en  = 1'b1;
                cmd.wr_sel = ile_pkg::WR_DOWN;
                if (stat.ptr_at_last)
                begin
                    cmd.cnt_op = ile_pkg::CNT_DEC;
                    state_next = S_FINISH;
                end
                else
                begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = ile_pkg::RD_NEXT;
                end
            end
            S_FINISH:
            begin
                if (stat.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // an accepted word is always decoded in the next cycle
    a_accept_decides: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (state_reg == S_DECIDE))
        else $error("accepted word not decoded");

    // the result is only handed over from the finish step
    a_out_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (state_reg == S_FINISH))
        else $error("result loaded outside finish");

endmodule

// ----- hw/rtl/ile_dp.sv -----
// ============================================================================
// ile_dp: list datapath
// Entry store (one write, one registered read per cycle), entry count,
// shift pointer, latched operation and the output result register.
// ============================================================================
module ile_dp (
    input  logic               clk,
    input  logic               rst_n,
    input  ile_pkg::ile_in_t   in_data,
    input  ile_pkg::ile_cmd_t  cmd,
    output ile_pkg::ile_stat_t stat,
    output logic               out_valid,
    input  logic               out_ready,
    output ile_pkg::ile_out_t  out_data
);

    logic [ile_pkg::PAYLOAD_BITS-1:0] store_mem [ile_pkg::CAPACITY];

    logic [ile_pkg::MODE_W-1:0]       mode_reg;
    logic [ile_pkg::POS_W-1:0]        pos_reg;
    logic [ile_pkg::PAYLOAD_BITS-1:0] word_reg;
    logic [ile_pkg::CNT_W-1:0]        count_reg;
    logic [ile_pkg::CNT_W-1:0]        count_next;
    logic [ile_pkg::ADDR_W-1:0]       ptr_reg;
    logic [ile_pkg::PAYLOAD_BITS-1:0] rd_data_reg;
    logic [ile_pkg::PAYLOAD_BITS-1:0] res_word_reg;
    logic [ile_pkg::STATUS_W-1:0]     status_reg;
    logic                             out_valid_reg;
    ile_pkg::ile_out_t                out_data_reg;

    logic [ile_pkg::CNT_W-1:0]        count_m1;
    logic [ile_pkg::ADDR_W-1:0]       rd_addr;
    logic [ile_pkg::ADDR_W-1:0]       wr_addr;
    logic [ile_pkg::PAYLOAD_BITS-1:0] wr_data;

    assign count_m1 = count_reg - ile_pkg::CNT_W'(1);

    // status toward the controller
    always_comb
    begin
        stat.mode        = mode_reg;
        stat.is_empty    = (count_reg == '0);
        stat.is_full     = (count_reg == ile_pkg::CNT_W'(ile_pkg::CAPACITY));
        stat.pos_gt_cnt  = (pos_reg > count_reg);
        stat.pos_ge_cnt  = (pos_reg >= count_reg);
        stat.pos_eq_cnt  = (pos_reg == count_reg);
        stat.ptr_at_pos  = (ile_pkg::CNT_W'(ptr_reg) == pos_reg);
        stat.ptr_at_last = (ile_pkg::CNT_W'(ptr_reg) == count_m1);
        stat.out_free    = !out_valid_reg || out_ready;
    end

    // read address select
    always_comb
    begin
        case (cmd.rd_sel)
            ile_pkg::RD_POS:  rd_addr = pos_reg[ile_pkg::ADDR_W-1:0];
            ile_pkg::RD_LAST: rd_addr = count_m1[ile_pkg::ADDR_W-1:0];
            ile_pkg::RD_PREV: rd_addr = ptr_reg - ile_pkg::ADDR_W'(1);
            ile_pkg::RD_NEXT: rd_addr = ptr_reg + ile_pkg::ADDR_W'(1);
            default:          rd_addr = ptr_reg;
        endcase
    end

    // write address and data select
    always_comb
    begin
        case (cmd.wr_sel)
            ile_pkg::WR_TAIL:
            begin
                wr_addr = count_reg[ile_pkg::ADDR_W-1:0];
                wr_data = word_reg;
            end
            ile_pkg::WR_POS:
            begin
                wr_addr = pos_reg[ile_pkg::ADDR_W-1:0];
                wr_data = word_reg;
            end
            ile_pkg::WR_UP:
            begin
                wr_addr = ptr_reg + ile_pkg::ADDR_W'(1);
                wr_data = rd_data_reg;
            end
            ile_pkg::WR_DOWN:
            begin
                wr_addr = ptr_reg - ile_pkg::ADDR_W'(1);
                wr_data = rd_data_reg;
            end
            default:
            begin
                wr_addr = ptr_reg;
                wr_data = rd_data_reg;
            end
        endcase
    end

    // entry store
    always_ff @(posedge clk)
    begin
        if (cmd.wr_en)
        begin
            store_mem[wr_addr] <= wr_data;
        end
        if (cmd.rd_en)
        begin
            rd_data_reg <= store_mem[rd_addr];
        end
    end

    // shift pointer follows the last read address
    always_ff @(posedge clk)
    begin
        if (cmd.rd_en)
        begin
            ptr_reg <= rd_addr;
        end
    end

    // latched operation and result word
    always_ff @(posedge clk)
    begin
        if (cmd.op_load)
        begin
            mode_reg     <= in_data.mode;
            pos_reg      <= in_data.position;
            word_reg     <= ile_pkg::PAYLOAD_BITS'(in_data.payload_in);
            res_word_reg <= '0;
        end
        else if (cmd.res_grab)
        begin
            res_word_reg <= rd_data_reg;
        end
        if (cmd.status_load)
        begin
            status_reg <= cmd.status_val;
        end
    end

    // entry count
    always_comb
    begin
        case (cmd.cnt_op)
            ile_pkg::CNT_INC: count_next = count_reg + ile_pkg::CNT_W'(1);
            ile_pkg::CNT_DEC: count_next = count_m1;
            ile_pkg::CNT_CLR: count_next = '0;
            default:          count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    // output result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_data_reg.status      <= status_reg;
            out_data_reg.payload_out <= ile_pkg::DATA_W'(res_word_reg);
            out_data_reg.count_after <= count_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // count never passes the capacity
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= ile_pkg::CNT_W'(ile_pkg::CAPACITY))
        else $error("entry count above capacity");

    // count moves by one or drops to zero
    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> ((count_reg == $past(count_reg)) ||
                  (count_reg == $past(count_reg) + ile_pkg::CNT_W'(1)) ||
                  (count_reg == $past(count_reg) - ile_pkg::CNT_W'(1)) ||
                  (count_reg == '0)))
        else $error("entry count jumped");

    // a new result never overwrites one still waiting
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!out_valid_reg || out_ready))
        else $error("pending result overwritten");

endmodule

// ----- hw/rtl/indexed_list_engine.sv -----
// ============================================================================
// indexed_list_engine: ordered list with insert/remove by index
// Keeps up to CAPACITY payload words in order; one operation per input word,
// one result word (status, payload, new length) per operation.
// ============================================================================
//
//  channel   dir   handshake               word
//  -------   ---   ---------------------   ----------------------------------
//  in        in    in_valid / in_ready     mode, position, payload_in
//  out       out   out_valid / out_ready   status, payload_out, count_after
//
//  Append, clear, error cases and unused modes go straight from decode to
//  the finish step; read and pop make one store read first; insert and
//  remove also shift the entries from the position to the end of the list,
//  one entry per cycle. Reset clears the entry count and the output valid
//  flag; the store is not cleared. A new word is taken once the previous
//  result sits in the output register; a stalled output holds the next
//  operation at its finish step.
//
module indexed_list_engine (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  ile_pkg::ile_in_t  in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output ile_pkg::ile_out_t out_data
);

    ile_pkg::ile_cmd_t  cmd;
    ile_pkg::ile_stat_t stat;

    // sequencer
    ile_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // store, count and result register
    ile_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (in_data),
        .cmd       (cmd),
        .stat      (stat),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

// ----- tb/tb.sv -----
// ============================================================================
// tb: self-checking testbench for the indexed list engine
// Drives list operations through the input handshake, predicts every result
// word with a behavioral copy of the list, and compares each result word
// field by field, under random idling, long output stalls and full lists.
// ============================================================================
`timescale 1ns / 1ps

module tb;

    // spare operation codes, no effect on the list
    localparam logic [ile_pkg::MODE_W-1:0] MODE_SPARE_A = 3'd6;
    localparam logic [ile_pkg::MODE_W-1:0] MODE_SPARE_B = 3'd7;

    // traffic mix for the random part
    localparam int MIX_GROW    = 0;
    localparam int MIX_SHRINK  = 1;
    localparam int MIX_BALANCE = 2;

    localparam int CYCLE_LIMIT  = 600000;
    localparam int LONG_HOLD    = 400;
    localparam int TAIL_CYCLES  = ile_pkg::CAPACITY + 16;
    localparam int DRAIN_GUARD  = 20000;
    localparam int MAX_REPORTS  = 10;

    typedef struct {
        ile_pkg::ile_in_t  cmd;
        ile_pkg::ile_out_t want;
    } pending_t;

    logic              clk;
    logic              rst_n;
    logic              in_valid;
    logic              in_ready;
    ile_pkg::ile_in_t  in_data;
    logic              out_valid;
    logic              out_ready;
    ile_pkg::ile_out_t out_data;

    // shadow copy of the list
    logic [ile_pkg::DATA_W-1:0] list_words [ile_pkg::CAPACITY];
    int                         list_len;

    pending_t pending_results [$];
    int       fail_count;
    int       cycle_count;
    bit       src_gap_on;
    bit       sink_stall_on;
    int       sink_hold;

    indexed_list_engine uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // list behavior: apply one operation to the shadow list, return the word
    // ------------------------------------------------------------------------
    function automatic ile_pkg::ile_out_t apply_list_op(ile_pkg::ile_in_t cmd);
        ile_pkg::ile_out_t r;
        int                p;
        int                i;
        p = int'(cmd.position);
        r.status      = ile_pkg::ST_OK;
        r.payload_out = '0;
        case (cmd.mode)
            ile_pkg::MODE_APPEND:
            begin
                if (list_len >= ile_pkg::CAPACITY)
                    r.status = ile_pkg::ST_FULL;
                else
                begin
                    list_words[list_len] = cmd.payload_in;
                    list_len++;
                end
            end
            ile_pkg::MODE_INSERT:
            begin
                // range check wins over full
                if (p > list_len)
                    r.status = ile_pkg::ST_RANGE;
                else if (list_len >= ile_pkg::CAPACITY)
                    r.status = ile_pkg::ST_FULL;
                else
                begin
                    for (i = list_len; i > p; i--)
                        list_words[i] = list_words[i-1];
                    list_words[p] = cmd.payload_in;
                    list_len++;
                end
            end
            ile_pkg::MODE_READ:
            begin
                if (p >= list_len)
                    r.status = ile_pkg::ST_RANGE;
                else
                    r.payload_out = list_words[p];
            end
            ile_pkg::MODE_POP:
            begin
                if (list_len == 0)
                    r.status = ile_pkg::ST_EMPTY;
                else
                begin
                    r.payload_out = list_words[list_len-1];
                    list_len--;
                end
            end
            ile_pkg::MODE_REMOVE:
            begin
                // empty check wins over range
                if (list_len == 0)
                    r.status = ile_pkg::ST_EMPTY;
                else if (p >= list_len)
                    r.status = ile_pkg::ST_RANGE;
                else
                begin
                    r.payload_out = list_words[p];
                    for (i = p; i < list_len - 1; i++)
                        list_words[i] = list_words[i+1];
                    list_len--;
                end
            end
            ile_pkg::MODE_CLEAR:
                list_len = 0;
            default: ;
        endcase
        r.count_after = ile_pkg::CNT_W'(list_len);
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // sender: offer one word, hold it until taken, then predict its result
    // ------------------------------------------------------------------------
    task automatic send_word(input ile_pkg::ile_in_t cmd);
        pending_t p;
        int       gap;
        if (src_gap_on && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 8);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= cmd;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        p.cmd  = cmd;
        p.want = apply_list_op(cmd);
        pending_results.push_back(p);
    endtask

    task automatic send_op(input logic [ile_pkg::MODE_W-1:0] mode, input int pos,
                           input logic [ile_pkg::DATA_W-1:0] data);
        ile_pkg::ile_in_t cmd;
        cmd.mode       = mode;
        cmd.position   = ile_pkg::POS_W'(pos);
        cmd.payload_in = data;
        send_word(cmd);
    endtask

    // sender pause until every result word is back
    task automatic wait_results_done();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_results.size() != 0);
    endtask

    task automatic note_failure(input string msg);
        fail_count++;
        if (fail_count <= MAX_REPORTS)
            $display("[%0t] ERROR: %s", $realtime, msg);
    endtask

    // ------------------------------------------------------------------------
    // random operation, mix shifted toward growing or shrinking the list
    // ------------------------------------------------------------------------
    function automatic ile_pkg::ile_in_t random_word(int mix);
        ile_pkg::ile_in_t cmd;
        int               r;
        r = $urandom_range(0, 99);
        if (mix == MIX_GROW)
            r = r * 70 / 100;
        else if (mix == MIX_SHRINK)
            r = 40 + r * 60 / 100;
        if (r < 25)
            cmd.mode = ile_pkg::MODE_APPEND;
        else if (r < 50)
            cmd.mode = ile_pkg::MODE_INSERT;
        else if (r < 65)
            cmd.mode = ile_pkg::MODE_READ;
        else if (r < 78)
            cmd.mode = ile_pkg::MODE_REMOVE;
        else if (r < 90)
            cmd.mode = ile_pkg::MODE_POP;
        else if (r < 94)
            cmd.mode = ile_pkg::MODE_CLEAR;
        else if (r < 97)
            cmd.mode = MODE_SPARE_A;
        else
            cmd.mode = MODE_SPARE_B;
        case ($urandom_range(0, 9))
            0:       cmd.position = ile_pkg::POS_W'($urandom_range(0, 127));
            1:       cmd.position = ile_pkg::POS_W'(list_len);
            2:       cmd.position = ile_pkg::POS_W'(list_len + 1);
            default: cmd.position = ile_pkg::POS_W'(
                         $urandom_range(0, list_len > 0 ? list_len - 1 : 0));
        endcase
        case ($urandom_range(0, 15))
            0:       cmd.payload_in = '0;
            1:       cmd.payload_in = '1;
            default: cmd.payload_in = $urandom;
        endcase
        return cmd;
    endfunction

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------

    // error paths on an empty list, then short shifts and all modes
    task automatic test_directed_cases();
        send_op(ile_pkg::MODE_READ,    0,   32'h1234_5678);
        send_op(ile_pkg::MODE_POP,     0,   '0);
        send_op(ile_pkg::MODE_REMOVE,  5,   '0);
        send_op(ile_pkg::MODE_REMOVE,  127, '1);
        send_op(ile_pkg::MODE_INSERT,  1,   32'hDEAD_BEEF);
        send_op(ile_pkg::MODE_CLEAR,   127, '1);
        send_op(MODE_SPARE_A,          0,   '0);
        send_op(MODE_SPARE_B,          127, '1);
        send_op(ile_pkg::MODE_INSERT,  0,   '1);
        send_op(ile_pkg::MODE_APPEND,  127, '0);
        send_op(ile_pkg::MODE_INSERT,  2,   32'hA5A5_A5A5);
        send_op(ile_pkg::MODE_INSERT,  1,   32'h5A5A_5A5A);
        send_op(MODE_SPARE_B,          2,   '1);
        send_op(ile_pkg::MODE_READ,    0,   '0);
        send_op(ile_pkg::MODE_READ,    3,   '0);
        send_op(ile_pkg::MODE_READ,    4,   '0);
        send_op(ile_pkg::MODE_READ,    127, '0);
        send_op(ile_pkg::MODE_REMOVE,  4,   '0);
        send_op(ile_pkg::MODE_REMOVE,  1,   '0);
        send_op(ile_pkg::MODE_REMOVE,  0,   '0);
        send_op(ile_pkg::MODE_POP,     0,   '0);
        send_op(ile_pkg::MODE_POP,     0,   '0);
        send_op(ile_pkg::MODE_POP,     0,   '0);
    endtask

    // fill to capacity, then full errors and the longest shifts
    task automatic test_full_list();
        send_op(ile_pkg::MODE_CLEAR, 0, '0);
        while (list_len < ile_pkg::CAPACITY)
        begin
            if ($urandom_range(0, 1) == 0)
                send_op(ile_pkg::MODE_APPEND, 0, $urandom);
            else
                send_op(ile_pkg::MODE_INSERT, $urandom_range(0, list_len), $urandom);
        end
        send_op(ile_pkg::MODE_APPEND, 0, '1);
        send_op(ile_pkg::MODE_INSERT, ile_pkg::CAPACITY, '1);
        send_op(ile_pkg::MODE_INSERT, ile_pkg::CAPACITY + 1, '1);
        send_op(ile_pkg::MODE_READ, ile_pkg::CAPACITY - 1, '0);
        send_op(ile_pkg::MODE_READ, ile_pkg::CAPACITY, '0);
        send_op(ile_pkg::MODE_REMOVE, 0, '0);
        send_op(ile_pkg::MODE_INSERT, 0, 32'hC0FF_EE00);
        send_op(ile_pkg::MODE_REMOVE, ile_pkg::CAPACITY, '0);
        send_op(ile_pkg::MODE_REMOVE, ile_pkg::CAPACITY - 1, '0);
        send_op(ile_pkg::MODE_POP, 0, '0);
        send_op(ile_pkg::MODE_READ, 0, '0);
    endtask

    // long output stall while words keep coming, then a full pause
    task automatic test_output_hold();
        int i;
        sink_hold = LONG_HOLD;
        for (i = 0; i < 12; i++)
            send_word(random_word(MIX_BALANCE));
        wait_results_done();
    endtask

    // random traffic in segments with changing mix and idling
    task automatic test_random_mix();
        int seg;
        int i;
        int mix;
        for (seg = 0; seg < 11; seg++)
        begin
            mix           = $urandom_range(MIX_GROW, MIX_BALANCE);
            src_gap_on    = ($urandom_range(0, 2) != 0);
            sink_stall_on = ($urandom_range(0, 2) != 0);
            for (i = 0; i < 100; i++)
                send_word(random_word(mix));
            if ($urandom_range(0, 2) == 0)
                wait_results_done();
        end
    endtask

    // closing stretch with no idling on either side
    task automatic test_steady_stream();
        int i;
        src_gap_on    = 1'b0;
        sink_stall_on = 1'b0;
        for (i = 0; i < 150; i++)
            send_word(random_word(i < 60 ? MIX_GROW : MIX_BALANCE));
    endtask

    // ------------------------------------------------------------------------
    // result sink: random stalls and the long hold
    // ------------------------------------------------------------------------
    initial
    begin : result_sink
        int n;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (sink_hold > 0)
            begin
                n = sink_hold;
                sink_hold = 0;
                out_ready <= 1'b0;
                repeat (n) @(posedge clk);
            end
            else if (sink_stall_on && $urandom_range(0, 4) == 0)
            begin
                n = $urandom_range(1, 8);
                out_ready <= 1'b0;
                repeat (n - 1) @(posedge clk);
            end
            else
                out_ready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------------
    // result check against the oldest pending word
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin : result_check
        pending_t p;
        if (rst_n === 1'b1 && out_valid === 1'b1 && out_ready === 1'b1)
        begin
            if (pending_results.size() == 0)
                note_failure($sformatf("result word with nothing pending: %0d %h %0d",
                             out_data.status, out_data.payload_out, out_data.count_after));
            else
            begin
                p = pending_results.pop_front();
                if (out_data.status !== p.want.status
                    || out_data.payload_out !== p.want.payload_out
                    || out_data.count_after !== p.want.count_after)
                    note_failure($sformatf({"mode %0d pos %0d data %h: expected ",
                                 "status %0d payload %h count %0d, got status %0d ",
                                 "payload %h count %0d"},
                                 p.cmd.mode, p.cmd.position, p.cmd.payload_in,
                                 p.want.status, p.want.payload_out, p.want.count_after,
                                 out_data.status, out_data.payload_out,
                                 out_data.count_after));
            end
        end
    end

    // ------------------------------------------------------------------------
    // watchdog
    // ------------------------------------------------------------------------
    initial
    begin : watchdog
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("[%0t] ERROR: timeout after %0d cycles", $realtime, cycle_count);
        $display("indexed_list_engine verification failed");
        $finish;
    end

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial
    begin : main_sequence
        int guard;
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        in_data       = '0;
        list_len      = 0;
        fail_count    = 0;
        sink_hold     = 0;
        src_gap_on    = 1'b1;
        sink_stall_on = 1'b1;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_cases();
        test_full_list();
        test_output_hold();
        test_random_mix();
        test_steady_stream();

        // drain, then let any stray word show up
        in_valid <= 1'b0;
        guard = 0;
        do
        begin
            @(posedge clk);
            guard++;
        end
        while (pending_results.size() != 0 && guard < DRAIN_GUARD);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (pending_results.size() != 0)
            note_failure($sformatf("%0d result words never arrived",
                         pending_results.size()));

        if (fail_count == 0)
            $display("indexed_list_engine verification clean");
        else
            $display("indexed_list_engine verification failed");
        $finish;
    end

endmodule
